// File: hdl/distinct_value_set_table_defines.svh
`ifndef DISTINCT_VALUE_SET_TABLE_DEFINES_SVH
`define DISTINCT_VALUE_SET_TABLE_DEFINES_SVH

// same-cycle check, disabled while reset is asserted
`define DVST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, disabled while reset is asserted
`define DVST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dvst_pkg.sv
`timescale 1ns / 1ps

package dvst_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // request operands broadcast to every cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] new_value;
  } req_t;

  // partial scan result passed from cell to cell
  typedef struct packed {
    logic hit;   // some earlier cell holds value
    logic nhit;  // some earlier cell holds new_value
    logic free;  // some earlier cell is empty
  } carry_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;   // write value into the lowest empty cell
    logic rem;   // invalidate the cell holding value
    logic rep;   // overwrite the cell holding value with new_value
  } cmd_t;

endpackage

// File: hdl/dvst_cell.sv
`timescale 1ns / 1ps

module dvst_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  dvst_pkg::req_t   req,
  input  dvst_pkg::cmd_t   cmd,
  input  dvst_pkg::carry_t carry_in,
  output dvst_pkg::carry_t carry_out
);
  import dvst_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic                      valid_r;
  logic                      valid_nxt;
  carry_t                    carry_r;
  carry_t                    carry_nxt;
  logic                      hit;
  logic                      nhit;
  logic                      first_free;

  // local compares against the broadcast request
  assign hit        = valid_r && (value_r == req.value);
  assign nhit       = valid_r && (value_r == req.new_value);
  assign first_free = !valid_r && !carry_in.free;

  // merge own flags into the running scan result
  always_comb begin
    carry_nxt.hit  = carry_in.hit  | hit;
    carry_nxt.nhit = carry_in.nhit | nhit;
    carry_nxt.free = carry_in.free | !valid_r;
  end

  // valid bit update
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.ins && first_free) begin
      valid_nxt = 1'b1;
    end
    if (cmd.rem && hit) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // slot value and scan stage
  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (cmd.ins && first_free) begin
      value_r <= req.value;
    end else if (cmd.rep && hit) begin
      value_r <= req.new_value;
    end
  end

  assign carry_out = carry_r;

endmodule

// File: hdl/dvst_ctrl.sv
`timescale 1ns / 1ps
`include "distinct_value_set_table_defines.svh"

module dvst_ctrl #(
  parameter int CAPACITY = dvst_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  dvst_pkg::op_t                        in_op,
  input  logic signed [dvst_pkg::VALUE_W-1:0]  in_value,
  input  logic signed [dvst_pkg::VALUE_W-1:0]  in_new_value,
  input  dvst_pkg::carry_t                     tot,
  output dvst_pkg::req_t                       req,
  output dvst_pkg::cmd_t                       cmd,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output dvst_pkg::status_t                    out_status,
  output logic                                 out_found,
  output logic [dvst_pkg::COUNT_OUT_W-1:0]     out_count
);
  import dvst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t             op_r, op_nxt;
  req_t            req_r, req_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic            found_r, found_nxt;
  logic [COUNT_OUT_W-1:0] count_r, count_nxt;
  logic            in_fire;
  logic            apply_fire;
  status_t         status_c;
  cmd_t            cmd_c;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // decide the outcome from the completed scan
  always_comb begin
    status_c = ST_OK;
    cmd_c    = '0;
    case (op_r)
      OP_INSERT: begin
        if (tot.hit) begin
          status_c = ST_DUPLICATE;
        end else if (!tot.free) begin
          status_c = ST_FULL;
        end else begin
          cmd_c.ins = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!tot.hit) begin
          status_c = ST_NOT_FOUND;
        end else begin
          cmd_c.rem = 1'b1;
        end
      end
      OP_QUERY: begin
        status_c = ST_OK;
      end
      OP_REPLACE: begin
        if (!tot.hit) begin
          status_c = ST_NOT_FOUND;
        end else if (tot.nhit) begin
          status_c = ST_DUPLICATE;
        end else begin
          cmd_c.rep = 1'b1;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign cmd = apply_fire ? cmd_c : '0;
  assign req = req_r;

  // next-state and registered outputs
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt            = in_op;
          req_nxt.value     = in_value;
          req_nxt.new_value = in_new_value;
          scan_nxt          = '0;
          state_nxt         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = S_APPLY;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      S_APPLY: begin
        if (apply_fire) begin
          if (cmd_c.ins) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (cmd_c.rem) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          status_nxt    = status_c;
          found_nxt     = tot.hit;
          count_nxt     = COUNT_OUT_W'(cnt_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    count_r  <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_status = status_r;
  assign out_found  = found_r;
  assign out_count  = count_r;

  // checks
  `DVST_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `DVST_ASSERT_NOW(a_apply_room, apply_fire, !out_valid_r || out_tready, "result overwritten")
  `DVST_ASSERT_NEXT(a_ins_count, apply_fire && cmd_c.ins, cnt_r == $past(cnt_r) + CNT_W'(1), "insert did not count")
  `DVST_ASSERT_NOW(a_busy_block, state_r != S_IDLE, !in_tready, "item taken while busy")

endmodule

// File: hdl/distinct_value_set_table.sv
`timescale 1ns / 1ps
// channel   direction  tdata                              tuser
// in_       slave      [31:0] value, [63:32] new_value    [1:0] op
// out_      master     [0] found, [5:1] count             [1:0] status
//
// each item passes through accept, then a scan that ripples through the chain
// of slot cells, then an update
// synchronous active-low reset empties every slot and clears the count
// a stalled result holds back the update; the next item is taken as soon
// as the result sits in the output register

module distinct_value_set_table #(
  parameter int CAPACITY = dvst_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value, new_value
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // found, count, zero fill
  output logic [1:0]  out_tuser   // status
);
  import dvst_pkg::*;

  req_t   req;
  cmd_t   cmd;
  carry_t chain [CAPACITY+1];
  status_t out_status;
  logic    out_found;
  logic [COUNT_OUT_W-1:0] out_count;

  assign chain[0] = '0;

  // slot cells, scan flows from cell 0 upward
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dvst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .cmd       (cmd),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

  dvst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_op        (op_t'(in_tuser)),
    .in_value     (in_tdata[31:0]),
    .in_new_value (in_tdata[63:32]),
    .tot          (chain[CAPACITY]),
    .req          (req),
    .cmd          (cmd),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_count    (out_count)
  );

  // pack the result item
  assign out_tdata = {2'b00, out_count, out_found};
  assign out_tuser = out_status;

endmodule
